FILE: rtl/core/rbd_pkg.sv
// Shared types and constants for the 2x2 RGB box downsampler.
// Used by rbd_position and rgb_box_downsample_2x2; depends on nothing else.
package rbd_pkg;

	localparam int CHAN_W         = 8;
	localparam int SUM_W          = 9;
	localparam int SRC_WIDTH_W    = 9;
	localparam int SRC_HEIGHT_W   = 13;
	localparam int ROW_W          = 12;
	localparam int CFG_DATA_W     = 13;
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int HEIGHT_LIMIT   = 4096;
	localparam int WIDTH_RESET    = 256;
	localparam int HEIGHT_RESET   = 256;

	// Configuration register indexes.
	localparam bit REG_SOURCE_WIDTH  = 1'b0;
	localparam bit REG_SOURCE_HEIGHT = 1'b1;

	// Horizontal pair sums, one 9-bit field per channel.
	typedef struct packed {
		logic [SUM_W-1:0] blue;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] red;
	} rgb_sum_t;

	// Decode of the current source position, handed from the position tracker.
	typedef struct packed {
		logic even_col;   // load the pair accumulator
		logic store_pair; // write the pair sum into the line store
		logic emit;       // a result is produced by this pixel
		logic row_end;
		logic image_end;
	} pos_ctl_t;

endpackage

FILE: rtl/core/rbd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package dependency.
module rbd_ram #(
	parameter int WIDTH = 27,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/core/rbd_position.sv
// Configuration registers and source position tracking for the downsampler.
// Depends on rbd_pkg for field widths, register indexes and the control struct.
module rbd_position #(
	parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic                                  cfg_index,
	input  logic [rbd_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  advance,
	output rbd_pkg::pos_ctl_t                     ctl,
	output logic [(MAX_WIDTH / 2 > 1 ? $clog2(MAX_WIDTH / 2) : 1)-1:0] pair_addr
);

	localparam int LineDepth = MAX_WIDTH / 2;
	localparam int AddrW     = (LineDepth > 1) ? $clog2(LineDepth) : 1;
	localparam int ColW      = $clog2(MAX_WIDTH);
	localparam int EffW      = $clog2(MAX_WIDTH + 1);
	localparam int CmpW      = (EffW > rbd_pkg::SRC_WIDTH_W) ? EffW : rbd_pkg::SRC_WIDTH_W;
	localparam int HW        = rbd_pkg::SRC_HEIGHT_W;
	localparam int RW        = rbd_pkg::ROW_W;

	logic [rbd_pkg::SRC_WIDTH_W-1:0]  width_q;
	logic [rbd_pkg::SRC_HEIGHT_W-1:0] height_q;
	logic [ColW-1:0]                  col_q;
	logic [RW-1:0]                    row_q;

	logic [CmpW-1:0] width_ext;
	logic [EffW-1:0] eff_w;
	logic [EffW-1:0] half_w;
	logic [HW-1:0]   eff_h;
	logic [HW-1:0]   half_h;
	logic [ColW-1:0] pair;
	logic [EffW-1:0] pair_ext;
	logic [HW-1:0]   row_pair;
	logic            col_last;
	logic            row_last;
	logic            pair_ok;
	logic            row_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rbd_pkg::SRC_WIDTH_W'(rbd_pkg::WIDTH_RESET);
			height_q <= rbd_pkg::SRC_HEIGHT_W'(rbd_pkg::HEIGHT_RESET);
		end else if (cfg_write) begin
			case (cfg_index)
				rbd_pkg::REG_SOURCE_WIDTH: width_q <= cfg_data[rbd_pkg::SRC_WIDTH_W-1:0];
				rbd_pkg::REG_SOURCE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturate the registers to the supported image sizes.
	always_comb begin
		width_ext = CmpW'(width_q);
		if (width_ext < CmpW'(2)) begin
			eff_w = EffW'(2);
		end else if (width_ext > CmpW'(MAX_WIDTH)) begin
			eff_w = EffW'(MAX_WIDTH);
		end else begin
			eff_w = EffW'(width_ext);
		end
		if (height_q < HW'(2)) begin
			eff_h = HW'(2);
		end else if (height_q > HW'(rbd_pkg::HEIGHT_LIMIT)) begin
			eff_h = HW'(rbd_pkg::HEIGHT_LIMIT);
		end else begin
			eff_h = height_q;
		end
	end

	assign half_w   = eff_w >> 1;
	assign half_h   = eff_h >> 1;
	assign pair     = col_q >> 1;
	assign pair_ext = EffW'(pair);
	assign row_pair = HW'(row_q >> 1);
	assign col_last = (EffW'(col_q) + EffW'(1)) >= eff_w;
	assign row_last = (HW'(row_q) + HW'(1)) >= eff_h;
	assign pair_ok  = (pair_ext < half_w) && (pair < ColW'(LineDepth));
	assign row_ok   = row_pair < half_h;

	always_comb begin
		ctl.even_col   = !col_q[0];
		ctl.store_pair = col_q[0] && pair_ok && !row_q[0];
		ctl.emit       = col_q[0] && pair_ok && row_q[0] && row_ok;
		ctl.row_end    = (pair_ext + EffW'(1)) == half_w;
		ctl.image_end  = ctl.row_end && ((row_pair + HW'(1)) == half_h);
	end

	assign pair_addr = AddrW'(pair);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + ColW'(1);
			end
		end
	end

endmodule

FILE: rtl/core/rgb_box_downsample_2x2.sv
// Top level of the 2x2 RGB box downsampler (next mip level of an RGB8 image).
// Depends on rbd_pkg, rbd_position and rbd_ram.
// A result passes stage one and the output register after the transfer of the
// source pixel that completes its 2x2 block. Throughput: one source pixel per
// cycle unless in_stall, limited by the single line store read or write per transfer.
// Reset clears the position counters, the pipeline valids and sets both size
// registers to 256; the line store is not cleared and needs no clearing pass.
module rgb_box_downsample_2x2 #(
	parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic                           cfg_index,
	input  logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [rbd_pkg::CHAN_W-1:0]     in_red,
	input  logic [rbd_pkg::CHAN_W-1:0]     in_green,
	input  logic [rbd_pkg::CHAN_W-1:0]     in_blue,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [rbd_pkg::CHAN_W-1:0]     out_red,
	output logic [rbd_pkg::CHAN_W-1:0]     out_green,
	output logic [rbd_pkg::CHAN_W-1:0]     out_blue,
	output logic                           row_end,
	output logic                           image_end
);

	localparam int LineDepth = MAX_WIDTH / 2;
	localparam int AddrW     = (LineDepth > 1) ? $clog2(LineDepth) : 1;
	localparam int SumW      = rbd_pkg::SUM_W;
	localparam int SumBits   = $bits(rbd_pkg::rgb_sum_t);

	rbd_pkg::pos_ctl_t  ctl;
	logic [AddrW-1:0]   pair_addr;
	logic               in_accept;
	logic               out_free;
	logic               s1_move;

	rbd_pkg::rgb_sum_t  acc_q;
	rbd_pkg::rgb_sum_t  pair_sum;
	rbd_pkg::rgb_sum_t  above;
	logic [SumBits-1:0] above_raw;

	logic               valid_s1;
	rbd_pkg::rgb_sum_t  sum_s1;
	logic               row_end_s1;
	logic               image_end_s1;

	logic               out_valid_q;

	logic [SumW:0]      total_red;
	logic [SumW:0]      total_green;
	logic [SumW:0]      total_blue;

	// A new pixel is refused only while the first stage holds a result that
	// cannot move into the output register.
	assign out_free  = !out_valid_q || !out_stall;
	assign s1_move   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;

	rbd_position #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_position (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (in_accept),
		.ctl       (ctl),
		.pair_addr (pair_addr)
	);

	// Horizontal pair sum: the held even-column pixel plus the odd-column pixel
	// arriving now. Each channel fits in 9 bits without wrapping.
	always_comb begin
		pair_sum.red   = acc_q.red + SumW'(in_red);
		pair_sum.green = acc_q.green + SumW'(in_green);
		pair_sum.blue  = acc_q.blue + SumW'(in_blue);
	end

	always_ff @(posedge clk) begin
		if (in_accept && ctl.even_col) begin
			acc_q.red   <= SumW'(in_red);
			acc_q.green <= SumW'(in_green);
			acc_q.blue  <= SumW'(in_blue);
		end
	end

	// The line store keeps the pair sums of the last even row. An even row
	// writes the entry of its pair; the odd row below reads it back. The read
	// is only issued on a transfer, so the read data holds while stage one waits.
	rbd_ram #(
		.WIDTH (SumBits),
		.DEPTH (LineDepth)
	) u_line_store (
		.clk     (clk),
		.wr_en   (in_accept && ctl.store_pair),
		.wr_addr (pair_addr),
		.wr_data (pair_sum),
		.rd_en   (in_accept && ctl.emit),
		.rd_addr (pair_addr),
		.rd_data (above_raw)
	);

	assign above = rbd_pkg::rgb_sum_t'(above_raw);

	// Stage one carries the current pair sum alongside the line store read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= ctl.emit;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && ctl.emit) begin
			sum_s1       <= pair_sum;
			row_end_s1   <= ctl.row_end;
			image_end_s1 <= ctl.image_end;
		end
	end

	// Vertical sum of the two pair sums, then a truncating divide by four.
	assign total_red   = (SumW + 1)'(above.red) + (SumW + 1)'(sum_s1.red);
	assign total_green = (SumW + 1)'(above.green) + (SumW + 1)'(sum_s1.green);
	assign total_blue  = (SumW + 1)'(above.blue) + (SumW + 1)'(sum_s1.blue);

	// Output register: parts the input side from a stalled consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_red   <= total_red[SumW:2];
			out_green <= total_green[SumW:2];
			out_blue  <= total_blue[SumW:2];
			row_end   <= row_end_s1;
			image_end <= image_end_s1;
		end
	end

	assign out_valid = out_valid_q;

endmodule
